// ===== sv/dhbd_pkg.sv =====
package dhbd_pkg;

	// field widths
	localparam int LOGIT_W = 16;
	localparam int CELL_W  = 8;
	localparam int ANC_W   = 2;
	localparam int CH_W    = 8;
	localparam int CLS_W   = 7;
	localparam int Q16_W   = 16;
	localparam int RECIP_W = 17;
	localparam int TABLE_W = 48;
	localparam int CNT_W   = 8;

	// stream and register port widths
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = CH_W;
	localparam int M_TDATA_W = 88;
	localparam int APB_AW    = 6;
	localparam int APB_DW    = 64;
	localparam int REG_IDX_W = 3;

	// limits of the layer
	localparam int MAX_ANCHORS = 3;
	localparam int MAX_CLASSES = 128;
	localparam logic [CH_W-1:0] FIRST_CLASS = 8'd5;

	// exponential datapath
	localparam logic [15:0] LOG2E_K = 16'd47274;
	localparam int XE_W   = LOGIT_W + 1;
	localparam int T_W    = 22;
	localparam int IP_W   = 6;
	localparam int M_W    = 17;
	localparam int P_W    = 18;
	localparam int DIFF_W = 13;
	localparam int FR_W   = 12;
	localparam int FP_W   = DIFF_W + FR_W;
	localparam int E_W    = 32;
	localparam int D_W    = 33;
	localparam int MUL_AW = 24;
	localparam int PROD_W = MUL_AW + RECIP_W;
	localparam int SZ_W   = 36;

	// sigmoid divider
	localparam int DIV_BITS       = 2;
	localparam int DIV_STAGES     = Q16_W / DIV_BITS;
	localparam logic [D_W-1:0] DIV_INIT_REM = 33'd65536;

	// channel codes on the input
	localparam logic [CH_W-1:0] CH_CX  = 8'd0;
	localparam logic [CH_W-1:0] CH_CY  = 8'd1;
	localparam logic [CH_W-1:0] CH_W_  = 8'd2;
	localparam logic [CH_W-1:0] CH_H   = 8'd3;
	localparam logic [CH_W-1:0] CH_OBJ = 8'd4;

	typedef enum logic [2:0] {
		KIND_CX,
		KIND_CY,
		KIND_W,
		KIND_H,
		KIND_OBJ,
		KIND_CLASS
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THRESHOLD    = 3'd0,
		REG_CLASS_TOTAL  = 3'd1,
		REG_ANCHOR_TOTAL = 3'd2,
		REG_COL_RECIP    = 3'd3,
		REG_ROW_RECIP    = 3'd4,
		REG_ANCHOR_W     = 3'd5,
		REG_ANCHOR_H     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		kind_t             kind;
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		logic [ANC_W-1:0]  anc;
		logic [CLS_W-1:0]  cls;
	} tag_t;

	typedef struct packed {
		tag_t                   tag;
		logic [M_W-1:0]         m;
		logic signed [IP_W-1:0] ip;
		logic [D_W-1:0]         d;
		logic                   zero;
		logic                   sat;
		logic [D_W-1:0]         rem;
		logic [Q16_W-1:0]       q;
	} div_t;

	// 2^(k/16) in q.16, k from 0 to 16
	function automatic logic [P_W-1:0] pow2_frac(input logic [4:0] k);
		logic [P_W-1:0] v;
		case (k)
			5'd0:    v = 18'd65536;
			5'd1:    v = 18'd68438;
			5'd2:    v = 18'd71468;
			5'd3:    v = 18'd74632;
			5'd4:    v = 18'd77936;
			5'd5:    v = 18'd81386;
			5'd6:    v = 18'd84990;
			5'd7:    v = 18'd88752;
			5'd8:    v = 18'd92682;
			5'd9:    v = 18'd96785;
			5'd10:   v = 18'd101070;
			5'd11:   v = 18'd105545;
			5'd12:   v = 18'd110218;
			5'd13:   v = 18'd115097;
			5'd14:   v = 18'd120194;
			5'd15:   v = 18'd125515;
			5'd16:   v = 18'd131072;
			default: v = '0;
		endcase
		return v;
	endfunction

	// one restoring step, dividend bits below are zero; returns {quotient bit, remainder}
	function automatic logic [D_W:0] div_step(input logic [D_W-1:0] rem,
			input logic [D_W-1:0] d);
		logic [D_W:0] sh;
		logic [D_W:0] df;
		sh = {rem, 1'b0};
		df = sh - {1'b0, d};
		if (sh >= {1'b0, d}) begin
			return {1'b1, df[D_W-1:0]};
		end
		return {1'b0, sh[D_W-1:0]};
	endfunction

endpackage

// ===== sv/detection_head_box_decode_top.sv =====
// detection head box decoder: takes one raw output value of a detector layer per beat, tagged
// with cell column, cell row, anchor and channel, and for every class channel that beats the
// score threshold (with its objectness) returns one beat holding the box of that cell and
// anchor, the class score and the class number. per cell and anchor the stream must carry the
// box channels (x, y, w, h) first, then objectness, then the classes; the held box is used as
// it stands. beats whose anchor is not below anchor_total, and class channels beyond
// class_total, are taken and dropped. one beat is taken every cycle unless the input stalls; each
// beat passes the input register, the exponential stages and the sigmoid reciprocal, a divider
// that resolves two quotient bits per stage over eight stages. the input only stalls when a
// result reaches the last stage while the output register still holds an unclaimed beat and
// no bubble is left behind it. registers are written through the apb port at byte address
// 8*index and should only be changed while the block is empty.
module detection_head_box_decode_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// logit[15:0], cell_col[23:16], cell_row[31:24], anchor_pick[33:32], zero pad
	input  logic [dhbd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// channel_pick[7:0]
	input  logic [dhbd_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// box_center_x[15:0], box_center_y[31:16], box_width[47:32], box_height[63:48],
	// class_score[79:64], class_number[86:80], zero pad
	output logic [dhbd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dhbd_pkg::APB_AW-1:0]     paddr,
	input  logic [dhbd_pkg::APB_DW-1:0]     pwdata,
	output logic [dhbd_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);
	import dhbd_pkg::*;

	// configuration registers
	logic [Q16_W-1:0]   thr_q;
	logic [CNT_W-1:0]   class_total_q;
	logic [ANC_W-1:0]   anchor_total_q;
	logic [RECIP_W-1:0] col_recip_q;
	logic [RECIP_W-1:0] row_recip_q;
	logic [TABLE_W-1:0] anc_w_q;
	logic [TABLE_W-1:0] anc_h_q;

	cfg_reg_t cfg_idx;
	logic     cfg_we;

	// held box and objectness
	logic [Q16_W-1:0] held_cx_q;
	logic [Q16_W-1:0] held_cy_q;
	logic [Q16_W-1:0] held_w_q;
	logic [Q16_W-1:0] held_h_q;
	logic [Q16_W-1:0] held_obj_q;
	logic             obj_pass_q;

	// input decode
	logic [LOGIT_W-1:0] in_logit;
	logic [ANC_W-1:0]   in_anc;
	logic [CH_W-1:0]    in_cls;
	logic               in_anc_ok;
	logic               in_keep;
	tag_t               in_tag;

	// stage 1: input register
	logic                      v_s1;
	tag_t                      tag_s1;
	logic signed [LOGIT_W-1:0] logit_s1;
	logic signed [XE_W-1:0]    xe;
	logic signed [XE_W*2-1:0]  y_full;

	// stage 2: log2(e) * x
	logic                v_s2;
	tag_t                tag_s2;
	logic [T_W-1:0]      t_s2;
	logic [P_W-1:0]      pk;
	logic [P_W-1:0]      pk1;
	logic [P_W-1:0]      pdiff;
	logic [FP_W-1:0]     fr_prod;

	// stage 3: interpolation product
	logic                   v_s3;
	tag_t                   tag_s3;
	logic [M_W-1:0]         pk_s3;
	logic [FP_W-1:0]        fr_s3;
	logic signed [IP_W-1:0] ip_s3;
	logic [M_W-1:0]         m_c;
	logic [IP_W-1:0]        nip;
	logic [E_W-1:0]         e_c;

	// stage 4: mantissa, exponent and divisor
	logic                   v_s4;
	tag_t                   tag_s4;
	logic [M_W-1:0]         m_s4;
	logic signed [IP_W-1:0] ip_s4;
	logic [D_W-1:0]         d_s4;
	logic                   zero_s4;
	logic                   sat_s4;

	// divider stages
	logic [DIV_STAGES-1:0] v_dv;
	div_t                  dv_s  [DIV_STAGES];
	div_t                  dv_src[DIV_STAGES];
	div_t                  dv_nx [DIV_STAGES];
	logic [DIV_STAGES-1:0] take_dv;

	// last divider stage: state read, multiplier
	div_t               last;
	logic [Q16_W-1:0]   sig;
	logic [Q16_W-1:0]   aw;
	logic [Q16_W-1:0]   ah;
	logic [MUL_AW-1:0]  mul_a;
	logic [RECIP_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;

	// stage 13: product, final shaping
	logic                   v_s13;
	tag_t                   tag_s13;
	logic [PROD_W-1:0]      prod_s13;
	logic signed [IP_W-1:0] ip_s13;
	logic                   pass_s13;
	logic [Q16_W-1:0]       cen;
	logic [Q16_W-1:0]       size;
	logic [Q16_W-1:0]       score;
	logic signed [IP_W:0]   sh7;
	logic [IP_W:0]          nsh;
	logic [SZ_W-1:0]        sz_v;
	logic                   res13;

	// output register
	logic             out_v_q;
	logic [Q16_W-1:0] out_cx_q;
	logic [Q16_W-1:0] out_cy_q;
	logic [Q16_W-1:0] out_w_q;
	logic [Q16_W-1:0] out_h_q;
	logic [Q16_W-1:0] out_score_q;
	logic [CLS_W-1:0] out_cls_q;

	// flow control
	logic out_take;
	logic take_s13;
	logic take_s4;
	logic take_s3;
	logic take_s2;
	logic take_s1;

	// ---------------------------------------------------------------- register port

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q          <= 16'd32768;
			class_total_q  <= 8'd80;
			anchor_total_q <= 2'd3;
			col_recip_q    <= 17'd4096;
			row_recip_q    <= 17'd4096;
			anc_w_q        <= '0;
			anc_h_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD:    thr_q          <= pwdata[Q16_W-1:0];
				REG_CLASS_TOTAL:  class_total_q  <= pwdata[CNT_W-1:0];
				REG_ANCHOR_TOTAL: anchor_total_q <= pwdata[ANC_W-1:0];
				REG_COL_RECIP:    col_recip_q    <= pwdata[RECIP_W-1:0];
				REG_ROW_RECIP:    row_recip_q    <= pwdata[RECIP_W-1:0];
				REG_ANCHOR_W:     anc_w_q        <= pwdata[TABLE_W-1:0];
				REG_ANCHOR_H:     anc_h_q        <= pwdata[TABLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_THRESHOLD:    prdata = APB_DW'(thr_q);
			REG_CLASS_TOTAL:  prdata = APB_DW'(class_total_q);
			REG_ANCHOR_TOTAL: prdata = APB_DW'(anchor_total_q);
			REG_COL_RECIP:    prdata = APB_DW'(col_recip_q);
			REG_ROW_RECIP:    prdata = APB_DW'(row_recip_q);
			REG_ANCHOR_W:     prdata = APB_DW'(anc_w_q);
			REG_ANCHOR_H:     prdata = APB_DW'(anc_h_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control

	// every stage moves on when the one after it is empty or moving; only a class hit
	// in the last stage waits for the output register
	assign out_take = !out_v_q || m_axis_tready;

	always_comb begin
		take_s13 = !v_s13 || !res13 || out_take;
		take_dv[DIV_STAGES-1] = !v_dv[DIV_STAGES-1] || take_s13;
		for (int j = DIV_STAGES - 2; j >= 0; j--) begin
			take_dv[j] = !v_dv[j] || take_dv[j+1];
		end
		take_s4 = !v_s4 || take_dv[0];
		take_s3 = !v_s3 || take_s4;
		take_s2 = !v_s2 || take_s3;
		take_s1 = !v_s1 || take_s2;
	end

	assign s_axis_tready = take_s1;

	// ---------------------------------------------------------------- input decode

	assign in_logit = s_axis_tdata[LOGIT_W-1:0];
	assign in_anc   = s_axis_tdata[2*CELL_W+LOGIT_W+ANC_W-1:2*CELL_W+LOGIT_W];
	assign in_cls   = s_axis_tuser - FIRST_CLASS;

	// anchors beyond the layer's count are dropped at the door
	assign in_anc_ok = (in_anc < anchor_total_q) && (in_anc < ANC_W'(MAX_ANCHORS));

	always_comb begin
		in_tag.col = s_axis_tdata[LOGIT_W+CELL_W-1:LOGIT_W];
		in_tag.row = s_axis_tdata[LOGIT_W+2*CELL_W-1:LOGIT_W+CELL_W];
		in_tag.anc = in_anc;
		in_tag.cls = in_cls[CLS_W-1:0];
		in_keep    = in_anc_ok;
		case (s_axis_tuser)
			CH_CX:   in_tag.kind = KIND_CX;
			CH_CY:   in_tag.kind = KIND_CY;
			CH_W_:   in_tag.kind = KIND_W;
			CH_H:    in_tag.kind = KIND_H;
			CH_OBJ:  in_tag.kind = KIND_OBJ;
			default: begin
				in_tag.kind = KIND_CLASS;
				in_keep     = in_anc_ok && (in_cls < class_total_q)
					&& ({1'b0, in_cls} < (CH_W + 1)'(MAX_CLASSES));
			end
		endcase
	end

	// ---------------------------------------------------------------- stage 1 to 2

	// box size wants exp(x), everything else wants exp(-x) for the sigmoid
	always_comb begin
		if (tag_s1.kind == KIND_W || tag_s1.kind == KIND_H) begin
			xe = {logit_s1[LOGIT_W-1], logit_s1};
		end else begin
			xe = -{logit_s1[LOGIT_W-1], logit_s1};
		end
		y_full = xe * $signed({1'b0, LOG2E_K});
	end

	// ---------------------------------------------------------------- stage 2 to 3

	// t = floor(y / 1024): fraction picks a segment of 2^f, top bits are the exponent
	always_comb begin
		pk      = pow2_frac({1'b0, t_s2[15:12]});
		pk1     = pow2_frac({1'b0, t_s2[15:12]} + 5'd1);
		pdiff   = pk1 - pk;
		fr_prod = pdiff[DIFF_W-1:0] * t_s2[FR_W-1:0];
	end

	// ---------------------------------------------------------------- stage 3 to 4

	always_comb begin
		m_c = pk_s3 + M_W'(fr_s3[FP_W-1:FR_W]);
		nip = -ip_s3;
		if (!ip_s3[IP_W-1]) begin
			e_c = E_W'(m_c) << ip_s3[3:0];
		end else begin
			e_c = E_W'(m_c >> nip);
		end
	end

	// ---------------------------------------------------------------- pipeline registers

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_dv  <= '0;
			v_s13 <= 1'b0;
		end else begin
			if (take_s1) begin
				v_s1 <= s_axis_tvalid && in_keep;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			if (take_s3) begin
				v_s3 <= v_s2;
			end
			if (take_s4) begin
				v_s4 <= v_s3;
			end
			for (int j = 0; j < DIV_STAGES; j++) begin
				if (take_dv[j]) begin
					v_dv[j] <= (j == 0) ? v_s4 : v_dv[(j == 0) ? 0 : j - 1];
				end
			end
			if (take_s13) begin
				v_s13 <= v_dv[DIV_STAGES-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			tag_s1   <= in_tag;
			logit_s1 <= in_logit;
		end
		if (take_s2) begin
			tag_s2 <= tag_s1;
			t_s2   <= y_full[T_W+9:10];
		end
		if (take_s3) begin
			tag_s3 <= tag_s2;
			pk_s3  <= pk[M_W-1:0];
			fr_s3  <= fr_prod;
			ip_s3  <= t_s2[T_W-1:T_W-IP_W];
		end
		if (take_s4) begin
			tag_s4  <= tag_s3;
			m_s4    <= m_c;
			ip_s4   <= ip_s3;
			d_s4    <= DIV_INIT_REM + D_W'(e_c);
			// exp(-x) of 2^16 or more leaves nothing; below 2^-16 the sigmoid saturates to all ones
			zero_s4 <= !ip_s3[IP_W-1] && ip_s3[4];
			sat_s4  <= ip_s3[IP_W-1] && (nip >= 6'd17);
		end
		for (int j = 0; j < DIV_STAGES; j++) begin
			if (take_dv[j]) begin
				dv_s[j] <= dv_nx[j];
			end
		end
		if (take_s13) begin
			tag_s13  <= last.tag;
			prod_s13 <= mul_p;
			ip_s13   <= last.ip;
			pass_s13 <= obj_pass_q;
		end
	end

	// ---------------------------------------------------------------- sigmoid divider

	// 2^32 / (65536 + e): the quotient is below 2^16 so the first remainder is 2^16
	always_comb begin
		dv_src[0].tag  = tag_s4;
		dv_src[0].m    = m_s4;
		dv_src[0].ip   = ip_s4;
		dv_src[0].d    = d_s4;
		dv_src[0].zero = zero_s4;
		dv_src[0].sat  = sat_s4;
		dv_src[0].rem  = DIV_INIT_REM;
		dv_src[0].q    = '0;
		for (int j = 1; j < DIV_STAGES; j++) begin
			dv_src[j] = dv_s[j-1];
		end
	end

	always_comb begin
		logic [D_W:0] st;
		for (int j = 0; j < DIV_STAGES; j++) begin
			dv_nx[j] = dv_src[j];
			for (int b = 0; b < DIV_BITS; b++) begin
				st           = div_step(dv_nx[j].rem, dv_nx[j].d);
				dv_nx[j].rem = st[D_W-1:0];
				dv_nx[j].q   = {dv_nx[j].q[Q16_W-2:0], st[D_W]};
			end
		end
	end

	// ---------------------------------------------------------------- objectness and multiply

	assign last = dv_s[DIV_STAGES-1];

	always_comb begin
		if (last.zero) begin
			sig = '0;
		end else if (last.sat) begin
			sig = '1;
		end else begin
			sig = last.q;
		end
	end

	always_comb begin
		case (last.tag.anc)
			2'd0: begin
				aw = anc_w_q[15:0];
				ah = anc_h_q[15:0];
			end
			2'd1: begin
				aw = anc_w_q[31:16];
				ah = anc_h_q[31:16];
			end
			2'd2: begin
				aw = anc_w_q[47:32];
				ah = anc_h_q[47:32];
			end
			default: begin
				aw = '0;
				ah = '0;
			end
		endcase
	end

	// one shared multiplier: centre offset by the grid reciprocal, anchor by the exponential,
	// or class sigmoid by the held objectness
	always_comb begin
		case (last.tag.kind)
			KIND_CX: begin
				mul_a = {last.tag.col, sig};
				mul_b = col_recip_q;
			end
			KIND_CY: begin
				mul_a = {last.tag.row, sig};
				mul_b = row_recip_q;
			end
			KIND_W: begin
				mul_a = MUL_AW'(aw);
				mul_b = last.m;
			end
			KIND_H: begin
				mul_a = MUL_AW'(ah);
				mul_b = last.m;
			end
			KIND_CLASS: begin
				mul_a = MUL_AW'(sig);
				mul_b = RECIP_W'(held_obj_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// ---------------------------------------------------------------- final stage

	always_comb begin
		// centre: drop the q.16 of the reciprocal and saturate
		if (|prod_s13[PROD_W-1:2*Q16_W]) begin
			cen = '1;
		end else begin
			cen = prod_s13[2*Q16_W-1:Q16_W];
		end

		// size: anchor * m * 2^ip / 2^20
		sh7 = 7'sd20 - $signed({ip_s13[IP_W-1], ip_s13});
		nsh = -sh7;
		if (sh7 <= 7'sd0) begin
			sz_v = SZ_W'(prod_s13[D_W-1:0]) << nsh[1:0];
		end else begin
			sz_v = SZ_W'(prod_s13[D_W-1:0] >> sh7[IP_W-1:0]);
		end
		if (|sz_v[SZ_W-1:Q16_W]) begin
			size = '1;
		end else begin
			size = sz_v[Q16_W-1:0];
		end

		score = prod_s13[2*Q16_W-1:Q16_W];
		res13 = v_s13 && (tag_s13.kind == KIND_CLASS) && pass_s13 && (score >= thr_q);
	end

	// state is read and written in the same stage so back-to-back beats see the update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			held_w_q   <= '0;
			held_h_q   <= '0;
			held_obj_q <= '0;
			obj_pass_q <= 1'b0;
		end else begin
			if (v_dv[DIV_STAGES-1] && take_s13 && last.tag.kind == KIND_OBJ) begin
				held_obj_q <= sig;
				obj_pass_q <= sig >= thr_q;
			end
			if (v_s13 && take_s13) begin
				case (tag_s13.kind)
					KIND_CX: held_cx_q <= cen;
					KIND_CY: held_cy_q <= cen;
					KIND_W:  held_w_q  <= size;
					KIND_H:  held_h_q  <= size;
					default: begin
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- output register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_take) begin
			out_v_q <= res13;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && res13) begin
			out_cx_q    <= held_cx_q;
			out_cy_q    <= held_cy_q;
			out_w_q     <= held_w_q;
			out_h_q     <= held_h_q;
			out_score_q <= score;
			out_cls_q   <= tag_s13.cls;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, out_cls_q, out_score_q, out_h_q, out_w_q, out_cy_q, out_cx_q};

endmodule
